FILE: src/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared sizes, status codes and sequencer states of the buddy allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int TOP_ORDER   = 10;
  localparam int NUM_ORDERS  = TOP_ORDER + 1;
  localparam int SLOT_W      = 12;
  localparam int TOTAL_PAGES = 2 ** SLOT_W;
  localparam int PAGE_SHIFT  = 12;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int LVL_W       = 4;
  localparam int STORE_AW    = LVL_W + SLOT_W;
  localparam int STORE_DEPTH = NUM_ORDERS * TOTAL_PAGES;
  localparam int PAGES_W     = 32 - PAGE_SHIFT + 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_CARVE,
    S_IDLE,
    S_A_ORD,
    S_A_SRCH,
    S_A_POPW,
    S_A_SPLIT,
    S_F_CHK,
    S_M_CHK,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_PUSH,
    S_FINISH
  } state_e;

endpackage

FILE: src/buddy_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator unit
// Allocates and frees power-of-two page blocks from per-order free lists,
// splitting on allocation and merging with buddies on free.
// ----------------------------------------------------------------------------
// Allocate: the order of the request is found, empty lists are skipped, a block
// is popped and split down to that order. A free scans the list of its order for
// the buddy, shifts the entries behind it and merges one order up until no buddy
// is found or the top order is reached, then pushes the block; an unknown free is reported.
// Throughput: one item at a time, the next accepted after the result is loaded.
// Reset: the order map is cleared entry by entry, then the lists are carved.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] request_bytes_i,
  input  logic [11:0] free_start_page_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] block_start_o,
  output logic [12:0] free_page_total_o
);

  localparam int SW = bpa_pkg::SLOT_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int LW = bpa_pkg::LVL_W;
  localparam int PW = bpa_pkg::PAGES_W;

  // Sequencer state and the working registers of the current item.
  bpa_pkg::state_e state_q, state_d;
  logic [PW-1:0]   pages_q, pages_d;
  logic [LW-1:0]   ord_q, ord_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [SW-1:0]   blk_q, blk_d;
  logic [CW-1:0]   k_q, k_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [SW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   free_q, free_d;
  logic [SW-1:0]   head_q [bpa_pkg::NUM_ORDERS];
  logic [SW-1:0]   head_d [bpa_pkg::NUM_ORDERS];
  logic [CW-1:0]   len_q  [bpa_pkg::NUM_ORDERS];
  logic [CW-1:0]   len_d  [bpa_pkg::NUM_ORDERS];
  bpa_pkg::status_e res_status_q, res_status_d;
  logic [SW-1:0]   res_start_q, res_start_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [SW-1:0]   out_start_q, out_start_d;
  logic [CW-1:0]   out_free_q, out_free_d;

  // Free block store: one circular list per order, addressed {order, slot}.
  logic [SW-1:0]   store_mem [bpa_pkg::STORE_DEPTH];
  logic                      st_we;
  logic [bpa_pkg::STORE_AW-1:0] st_waddr, st_raddr;
  logic [SW-1:0]             st_wdata, st_rdata_q;

  // Allocated order map: order plus one per start page, zero for none.
  logic [LW-1:0]   map_mem [bpa_pkg::TOTAL_PAGES];
  logic            map_we;
  logic [SW-1:0]   map_waddr;
  logic [LW-1:0]   map_wdata, map_rdata_q;

  logic            accept;
  logic            out_free_slot;
  logic [LW-1:0]   lvl_m1;
  logic [SW-1:0]   lvl_size;
  logic [SW-1:0]   buddy;
  logic [CW-1:0]   carve_size;
  logic [PW-1:0]   ord_size;

  assign accept        = in_valid_i && (state_q == bpa_pkg::S_IDLE);
  assign in_stall_o    = (state_q != bpa_pkg::S_IDLE);
  assign out_free_slot = !out_valid_q || !out_stall_i;
  assign lvl_m1        = lvl_q - LW'(1);
  assign lvl_size      = SW'(1) << lvl_q;
  assign buddy         = blk_q ^ lvl_size;
  assign carve_size    = CW'(1) << lvl_q;
  assign ord_size      = PW'(1) << ord_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_q <= map_mem[free_start_page_i];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        if (clr_q == SW'(bpa_pkg::TOTAL_PAGES - 1)) state_d = bpa_pkg::S_CARVE;
      end
      bpa_pkg::S_CARVE: begin
        if ((CW'(bpa_pkg::TOTAL_PAGES) - pos_q) < carve_size && lvl_q == '0) begin
          state_d = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (accept) state_d = cmd_i ? bpa_pkg::S_F_CHK : bpa_pkg::S_A_ORD;
      end
      bpa_pkg::S_A_ORD: begin
        if (ord_q == LW'(bpa_pkg::NUM_ORDERS)) state_d = bpa_pkg::S_FINISH;
        else if (ord_size >= pages_q)          state_d = bpa_pkg::S_A_SRCH;
      end
      bpa_pkg::S_A_SRCH: begin
        if (lvl_q == LW'(bpa_pkg::NUM_ORDERS)) state_d = bpa_pkg::S_FINISH;
        else if (len_q[lvl_q] != '0)           state_d = bpa_pkg::S_A_POPW;
      end
      bpa_pkg::S_A_POPW:  state_d = bpa_pkg::S_A_SPLIT;
      bpa_pkg::S_A_SPLIT: begin
        if (lvl_q <= ord_q) state_d = bpa_pkg::S_FINISH;
      end
      bpa_pkg::S_F_CHK: begin
        if (map_rdata_q == '0) state_d = bpa_pkg::S_FINISH;
        else                   state_d = bpa_pkg::S_M_CHK;
      end
      bpa_pkg::S_M_CHK: begin
        state_d = (lvl_q < LW'(bpa_pkg::TOP_ORDER)) ? bpa_pkg::S_RM_RD : bpa_pkg::S_PUSH;
      end
      bpa_pkg::S_RM_RD: begin
        state_d = (k_q >= len_q[lvl_q]) ? bpa_pkg::S_PUSH : bpa_pkg::S_RM_CMP;
      end
      bpa_pkg::S_RM_CMP: begin
        state_d = (st_rdata_q == buddy) ? bpa_pkg::S_SH_RD : bpa_pkg::S_RM_RD;
      end
      bpa_pkg::S_SH_RD: begin
        state_d = ((k_q + CW'(1)) < len_q[lvl_q]) ? bpa_pkg::S_SH_WR : bpa_pkg::S_M_CHK;
      end
      bpa_pkg::S_SH_WR: state_d = bpa_pkg::S_SH_RD;
      bpa_pkg::S_PUSH:  state_d = bpa_pkg::S_FINISH;
      bpa_pkg::S_FINISH: begin
        if (out_free_slot) state_d = bpa_pkg::S_IDLE;
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    pages_d      = pages_q;
    ord_d        = ord_q;
    lvl_d        = lvl_q;
    blk_d        = blk_q;
    k_d          = k_q;
    pos_d        = pos_q;
    clr_d        = clr_q;
    free_d       = free_q;
    head_d       = head_q;
    len_d        = len_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_free_d   = out_free_q;
    st_we        = 1'b0;
    st_waddr     = '0;
    st_wdata     = '0;
    st_raddr     = '0;
    map_we       = 1'b0;
    map_waddr    = '0;
    map_wdata    = '0;

    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        clr_d     = clr_q + SW'(1);
        lvl_d     = LW'(bpa_pkg::TOP_ORDER);
        pos_d     = '0;
      end
      bpa_pkg::S_CARVE: begin
        if ((CW'(bpa_pkg::TOTAL_PAGES) - pos_q) >= carve_size) begin
          if (len_q[lvl_q] < CW'(bpa_pkg::TOTAL_PAGES)) begin
            st_we          = 1'b1;
            st_waddr       = {lvl_q, head_q[lvl_q] + len_q[lvl_q][SW-1:0]};
            st_wdata       = pos_q[SW-1:0];
            len_d[lvl_q]   = len_q[lvl_q] + CW'(1);
          end
          pos_d = pos_q + carve_size;
        end else if (lvl_q != '0) begin
          lvl_d = lvl_m1;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (accept) begin
          pages_d = PW'(request_bytes_i >> bpa_pkg::PAGE_SHIFT)
                    + PW'(request_bytes_i[bpa_pkg::PAGE_SHIFT-1:0] != '0);
          if (pages_d == '0) pages_d = PW'(1);
          ord_d = '0;
          blk_d = free_start_page_i;
        end
      end
      bpa_pkg::S_A_ORD: begin
        if (ord_q == LW'(bpa_pkg::NUM_ORDERS)) begin
          res_status_d = bpa_pkg::ST_TOO_LARGE;
          res_start_d  = '0;
        end else if (ord_size >= pages_q) begin
          lvl_d = ord_q;
        end else begin
          ord_d = ord_q + LW'(1);
        end
      end
      bpa_pkg::S_A_SRCH: begin
        if (lvl_q == LW'(bpa_pkg::NUM_ORDERS)) begin
          res_status_d = bpa_pkg::ST_OOM;
          res_start_d  = '0;
        end else if (len_q[lvl_q] != '0) begin
          st_raddr      = {lvl_q, head_q[lvl_q]};
          head_d[lvl_q] = head_q[lvl_q] + SW'(1);
          len_d[lvl_q]  = len_q[lvl_q] - CW'(1);
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      bpa_pkg::S_A_POPW: begin
        blk_d = st_rdata_q;
      end
      bpa_pkg::S_A_SPLIT: begin
        if (lvl_q > ord_q) begin
          // The upper half goes to the tail of the next lower list.
          if (len_q[lvl_m1] < CW'(bpa_pkg::TOTAL_PAGES)) begin
            st_we          = 1'b1;
            st_waddr       = {lvl_m1, head_q[lvl_m1] + len_q[lvl_m1][SW-1:0]};
            st_wdata       = blk_q + (SW'(1) << lvl_m1);
            len_d[lvl_m1]  = len_q[lvl_m1] + CW'(1);
          end
          lvl_d = lvl_m1;
        end else begin
          map_we       = 1'b1;
          map_waddr    = blk_q;
          map_wdata    = ord_q + LW'(1);
          free_d       = free_q - (CW'(1) << ord_q);
          res_status_d = bpa_pkg::ST_OK;
          res_start_d  = blk_q;
        end
      end
      bpa_pkg::S_F_CHK: begin
        res_start_d = '0;
        if (map_rdata_q == '0) begin
          res_status_d = bpa_pkg::ST_UNKNOWN;
        end else begin
          lvl_d     = map_rdata_q - LW'(1);
          map_we    = 1'b1;
          map_waddr = blk_q;
          map_wdata = '0;
          free_d    = free_q + (CW'(1) << lvl_d);
        end
      end
      bpa_pkg::S_M_CHK: begin
        k_d = '0;
      end
      bpa_pkg::S_RM_RD: begin
        st_raddr = {lvl_q, head_q[lvl_q] + k_q[SW-1:0]};
      end
      bpa_pkg::S_RM_CMP: begin
        if (st_rdata_q != buddy) k_d = k_q + CW'(1);
      end
      bpa_pkg::S_SH_RD: begin
        if ((k_q + CW'(1)) < len_q[lvl_q]) begin
          st_raddr = {lvl_q, head_q[lvl_q] + k_q[SW-1:0] + SW'(1)};
        end else begin
          // Buddy removed: merge into the block one order up.
          len_d[lvl_q] = len_q[lvl_q] - CW'(1);
          blk_d        = blk_q & ~lvl_size;
          lvl_d        = lvl_q + LW'(1);
        end
      end
      bpa_pkg::S_SH_WR: begin
        st_we    = 1'b1;
        st_waddr = {lvl_q, head_q[lvl_q] + k_q[SW-1:0]};
        st_wdata = st_rdata_q;
        k_d      = k_q + CW'(1);
      end
      bpa_pkg::S_PUSH: begin
        if (len_q[lvl_q] < CW'(bpa_pkg::TOTAL_PAGES)) begin
          st_we        = 1'b1;
          st_waddr     = {lvl_q, head_q[lvl_q] + len_q[lvl_q][SW-1:0]};
          st_wdata     = blk_q;
          len_d[lvl_q] = len_q[lvl_q] + CW'(1);
        end
        res_status_d = bpa_pkg::ST_OK;
      end
      bpa_pkg::S_FINISH: begin
        if (out_free_slot) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = res_start_q;
          out_free_d   = free_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::S_CLEAR;
      clr_q       <= '0;
      lvl_q       <= '0;
      pos_q       <= '0;
      free_q      <= CW'(bpa_pkg::TOTAL_PAGES);
      out_valid_q <= 1'b0;
      for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) begin
        head_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lvl_q       <= lvl_d;
      pos_q       <= pos_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pages_q      <= pages_d;
    ord_q        <= ord_d;
    blk_q        <= blk_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_free_q   <= out_free_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign block_start_o     = out_start_q;
  assign free_page_total_o = out_free_q;

endmodule
